// ===== hw/rtl/smv_pkg.sv =====
`default_nettype none

package smv_pkg;

   localparam int POS_W = 12;
   localparam int VAL_W = 32;
   localparam int SUM_W = 64;
   // position zero-extended so that any store depth up to 65536 compares cleanly
   localparam int POS_WIDE_W = 17;
   localparam int VECTOR_DEPTH_DEF = 4096;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ENTRY = 1'b1
   } op_type;

   // control travelling with a matrix entry into the multiply stage
   typedef struct packed {
      logic valid;
      logic last;
      logic in_range;
   } issue_type;

   // one finished row
   typedef struct packed {
      logic [SUM_W-1:0] row_sum;
      logic [POS_W-1:0] row_number;
      logic             saturated;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/smv_if.sv =====
`default_nettype none

interface smv_req_if;
   import smv_pkg::*;

   logic             valid;
   logic             ready;
   logic             operation;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] value;
   logic             row_end;

   modport source (output valid, operation, position, value, row_end, input ready);
   modport sink (input valid, operation, position, value, row_end, output ready);
endinterface

interface smv_rsp_if;
   import smv_pkg::*;

   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] row_sum;
   logic [POS_W-1:0] row_number;
   logic             saturated;

   modport source (output valid, row_sum, row_number, saturated, input ready);
   modport sink (input valid, row_sum, row_number, saturated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smv_ram.sv =====
`default_nettype none

module smv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/smv_mac.sv =====
`default_nettype none

module smv_mac (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire smv_pkg::issue_type        issue,
   input  wire logic [smv_pkg::VAL_W-1:0] coef,
   input  wire logic [smv_pkg::VAL_W-1:0] elem_rd,
   output      logic                      s2_last_valid,
   output      logic                      res_valid,
   output      smv_pkg::result_type       res
);
   import smv_pkg::*;

   issue_type                s1_ff, s1_in;
   logic        [VAL_W-1:0]  coef_ff;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_last_ff, s2_last_in;
   logic signed [SUM_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic                     sat_ff, sat_in;
   logic        [POS_W-1:0]  row_ff, row_in;
   logic signed [VAL_W-1:0]  elem;
   logic        [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   logic                     hit;

   // multiply stage: out-of-range column reads as zero
   always_comb begin
      elem        = s1_ff.in_range ? signed'(elem_rd) : '0;
      prod_in     = signed'(coef_ff) * elem;
      s1_in       = issue;
      s2_valid_in = s1_ff.valid;
      s2_last_in  = s1_ff.last;
   end

   // saturating accumulate, 65-bit sum and sign check
   always_comb begin
      sum_wide = {acc_ff[SUM_W-1], acc_ff} + {prod_ff[SUM_W-1], prod_ff};
      hit      = sum_wide[SUM_W] != sum_wide[SUM_W-1];
      if (!hit) begin
         sum_sat = signed'(sum_wide[SUM_W-1:0]);
      end else if (sum_wide[SUM_W]) begin
         sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end

      res_valid      = advance && s2_valid_ff && s2_last_ff;
      res.row_sum    = sum_sat;
      res.row_number = row_ff;
      res.saturated  = sat_ff || hit;

      acc_in = acc_ff;
      sat_in = sat_ff;
      row_in = row_ff;
      if (advance && s2_valid_ff) begin
         if (s2_last_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
            row_in = row_ff + 1'b1;
         end else begin
            acc_in = sum_sat;
            sat_in = sat_ff || hit;
         end
      end
   end

   assign s2_last_valid = s2_valid_ff && s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
         acc_ff      <= '0;
         sat_ff      <= 1'b0;
         row_ff      <= '0;
      end else begin
         if (advance) begin
            s1_ff       <= s1_in;
            s2_valid_ff <= s2_valid_in;
            s2_last_ff  <= s2_last_in;
         end
         acc_ff <= acc_in;
         sat_ff <= sat_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_ff <= coef;
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sparse_row_matvec_core.sv =====
`default_nettype none

// Sparse row matrix times vector: one request per cycle unless stalled, loads and entries alike.
// A row-end entry's result passes through the vector store read, the multiply register
// and the accumulate into the output register before it shows.
// The pipeline stalls only while a finished row waits and another row end is behind it.
// Reset (synchronous) clears the pipeline, accumulator, row counter and flag;
// the vector store is not cleared and holds garbage until loaded.

module sparse_row_matvec_core #(
   parameter int VECTOR_DEPTH = smv_pkg::VECTOR_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   smv_req_if.sink    req_if,
   smv_rsp_if.source  rsp_if
);
   import smv_pkg::*;

   localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   logic                  advance;
   logic                  accept;
   logic [POS_WIDE_W-1:0] pos_wide;
   logic                  in_range;
   logic [ADDR_W-1:0]     addr;
   logic                  is_entry;
   issue_type             issue;
   logic [VAL_W-1:0]      elem_rd;
   logic                  s2_last_valid;
   logic                  res_valid;
   result_type            res;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;

   // Hold everything only when a row end would land on an output still waiting
   assign advance = !(s2_last_valid && rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = advance;
   assign accept = req_if.valid && advance;

   // Columns past the store read as zero; loads there are dropped
   assign pos_wide = POS_WIDE_W'(req_if.position);
   assign in_range = pos_wide < POS_WIDE_W'(VECTOR_DEPTH);
   assign addr     = pos_wide[ADDR_W-1:0];
   assign is_entry = op_type'(req_if.operation) == OP_ENTRY;

   always_comb begin
      issue.valid    = accept && is_entry;
      issue.last     = req_if.row_end;
      issue.in_range = in_range;
   end

   // Vector store; a load and a later entry never meet in one cycle,
   // so the registered read always sees the last write
   smv_ram #(
      .WIDTH (VAL_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (accept && !is_entry && in_range),
      .wr_addr (addr),
      .wr_data (req_if.value),
      .rd_en   (accept && is_entry),
      .rd_addr (addr),
      .rd_data (elem_rd)
   );

   smv_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .issue         (issue),
      .coef          (req_if.value),
      .elem_rd       (elem_rd),
      .s2_last_valid (s2_last_valid),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Output register
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.row_sum    = rsp_data_ff.row_sum;
   assign rsp_if.row_number = rsp_data_ff.row_number;
   assign rsp_if.saturated  = rsp_data_ff.saturated;

   // Back-pressure only ever comes from a waiting result
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("request side stalled without a waiting result");

   // A waiting result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !res_valid)
      else $error("new row result while output register occupied");

   // Nothing emerges right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid straight after reset");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for sparse_row_matvec_core.
// Requests: vector loads and matrix entries in row-compressed order. Each accepted
// request runs through a local predictor that keeps its own copy of the vector
// store, the Q32.32 accumulator, the row count and the saturation flag.
// Each finished row is queued as the expected row result and checked against the
// response channel in order.

module tb_top;
   import smv_pkg::*;

   localparam int STORE_DEPTH  = VECTOR_DEPTH_DEF;
   localparam int TAIL_ROWS    = 100;            // short rows at the end, no idling
   localparam int RANDOM_SEGS  = 6;
   localparam int SEG_REQUESTS = 280;            // six stretches of about 280 requests
   localparam int DRAIN_CYCLES = 16;             // well past the pipeline latency
   localparam int CYCLE_LIMIT  = 400_000;

   localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;
   localparam logic [VAL_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      op_type           operation;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic             row_end;
   } matvec_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   smv_req_if req_if ();
   smv_rsp_if rsp_if ();

   sparse_row_matvec_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Request stream built ahead of time by the initial block.
   // The loaded_* arrays mirror what has been queued so far, so that a
   // matrix entry only ever reads a vector element that was loaded first.
   // ------------------------------------------------------------------
   matvec_request_type request_backlog[$];
   bit                 loaded     [STORE_DEPTH];
   logic [VAL_W-1:0]   loaded_val [STORE_DEPTH];
   int                 loaded_cols[$];
   int                 last_loaded;
   int                 rows_issued;
   int                 requests_total;
   int                 requests_taken;

   // idling, in percent chance per request of starting a burst
   int req_idle_pct;
   int rsp_idle_pct;

   // ------------------------------------------------------------------
   // Predictor state
   // ------------------------------------------------------------------
   logic [VAL_W-1:0]        vec_shadow [STORE_DEPTH];
   logic signed [SUM_W-1:0] acc_shadow;
   logic [POS_W-1:0]        row_shadow;
   logic                    sat_shadow;
   result_type              rows_due[$];
   int                      mismatches;

   logic req_fire;

   task automatic queue_load(input int pos, input logic [VAL_W-1:0] val, input logic flag);
      request_backlog.push_back('{OP_LOAD, POS_W'(pos), val, flag});
      if (!loaded[pos])
         loaded_cols.push_back(pos);
      loaded[pos]     = 1'b1;
      loaded_val[pos] = val;
      last_loaded     = pos;
      requests_total++;
   endtask

   task automatic queue_entry(input int col, input logic [VAL_W-1:0] coef, input logic last);
      request_backlog.push_back('{OP_ENTRY, POS_W'(col), coef, last});
      if (last)
         rows_issued++;
      requests_total++;
   endtask

   // extremes, sign boundary, zero, small fractions and full-range noise
   function automatic logic [VAL_W-1:0] pick_value();
      int small_q;
      case ($urandom_range(0, 9))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return 32'hFFFF_FFFF;
         3: return '0;
         4, 5: begin
            small_q = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
            return VAL_W'(small_q);
         end
         default: return $urandom;
      endcase
   endfunction

   // a quarter of the time the most recent load, to hit the load-then-read path
   function automatic int pick_column();
      if ($urandom_range(0, 3) == 0)
         return last_loaded;
      return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
   endfunction

   // Q16.16 x Q16.16 is an exact Q32.32 product; the add saturates to 64 bits
   function automatic void predict_row_sum(input matvec_request_type rq);
      logic signed [SUM_W-1:0] coef;
      logic signed [SUM_W-1:0] elem;
      logic signed [SUM_W-1:0] prod;
      logic [SUM_W:0]          wide;
      result_type              done;
      if (rq.operation == OP_LOAD) begin
         if (int'(rq.position) < STORE_DEPTH)
            vec_shadow[rq.position] = rq.value;
         return;
      end
      coef = {{(SUM_W-VAL_W){rq.value[VAL_W-1]}}, rq.value};
      elem = '0;
      if (int'(rq.position) < STORE_DEPTH)
         elem = {{(SUM_W-VAL_W){vec_shadow[rq.position][VAL_W-1]}}, vec_shadow[rq.position]};
      prod = coef * elem;
      wide = {acc_shadow[SUM_W-1], acc_shadow} + {prod[SUM_W-1], prod};
      if (wide[SUM_W] != wide[SUM_W-1]) begin
         // clamp towards the sign of the true sum
         acc_shadow = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         sat_shadow = 1'b1;
      end else begin
         acc_shadow = wide[SUM_W-1:0];
      end
      if (rq.row_end) begin
         done.row_sum    = acc_shadow;
         done.row_number = row_shadow;
         done.saturated  = sat_shadow;
         rows_due.push_back(done);
         acc_shadow = '0;
         sat_shadow = 1'b0;
         row_shadow = row_shadow + 1'b1;
      end
   endfunction

   task automatic note_mismatch(input string what, input result_type want, input result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected sum %h row %0d sat %0b, got sum %h row %0d sat %0b",
                  $time, what, want.row_sum, want.row_number, want.saturated,
                  got.row_sum, got.row_number, got.saturated);
   endtask

   // ------------------------------------------------------------------
   // Request driver: changes on the falling edge. A request stays up until
   // the monitor has seen it taken; gaps come in bursts.
   // ------------------------------------------------------------------
   int req_gap_left = 0;

   always @(negedge clock) begin
      matvec_request_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (req_gap_left == 0 && req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct)
            req_gap_left = $urandom_range(1, 17);
         if (req_gap_left != 0 || request_backlog.size() == 0) begin
            if (req_gap_left != 0)
               req_gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            item = request_backlog.pop_front();
            req_if.valid     <= 1'b1;
            req_if.operation <= item.operation;
            req_if.position  <= item.position;
            req_if.value     <= item.value;
            req_if.row_end   <= item.row_end;
         end
      end
   end

   // Result back-pressure, in bursts as well
   int rsp_stall_left = 0;

   always @(negedge clock) begin
      if (rsp_stall_left == 0 && rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct)
         rsp_stall_left = $urandom_range(1, 17);
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples both channels on the rising edge. Results are checked
   // before the request of the same edge is predicted; the latency keeps the
   // two apart anyway.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.row_sum, rsp_if.row_number, rsp_if.saturated};
            if (rows_due.size() == 0) begin
               note_mismatch("row result with none outstanding", '0, got);
            end else begin
               want = rows_due.pop_front();
               if (got.row_sum !== want.row_sum || got.row_number !== want.row_number ||
                   got.saturated !== want.saturated)
                  note_mismatch("row result differs", want, got);
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_row_sum('{op_type'(req_if.operation), req_if.position, req_if.value,
                              req_if.row_end});
            requests_taken++;
         end
      end
   end

   // Watchdog
   int cycle_count = 0;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int               seg;
      int               goal;
      int               len;
      int               k;
      int               col;
      bit               heavy;
      bit               heavy_up;
      logic [VAL_W-1:0] coef;

      req_if.valid     = 1'b0;
      req_if.operation = OP_LOAD;
      req_if.position  = '0;
      req_if.value     = '0;
      req_if.row_end   = 1'b0;
      rsp_if.ready     = 1'b0;
      req_fire         = 1'b0;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      acc_shadow       = '0;
      row_shadow       = '0;
      sat_shadow       = 1'b0;
      mismatches       = 0;
      rows_issued      = 0;
      requests_total   = 0;
      requests_taken   = 0;
      last_loaded      = 0;

      // directed: extremes first, back to back with no idling
      queue_load(0, Q_MAX, 1'b0);
      queue_load(STORE_DEPTH - 1, Q_MIN, 1'b0);
      queue_load(1, Q_ONE, 1'b0);
      queue_load(2, 32'hFFFF_FFFF, 1'b1);          // row end on a load is ignored
      queue_load(12'hAAA, 32'h5555_5555, 1'b0);
      queue_load(12'h555, 32'hAAAA_AAAA, 1'b1);
      queue_entry(1, Q_ONE, 1'b1);                 // 1.0 * 1.0
      queue_entry(0, Q_MAX, 1'b0);                 // mixed signs, column extremes
      queue_entry(STORE_DEPTH - 1, Q_MIN, 1'b0);
      queue_entry(2, 32'hFFFF_FFFF, 1'b0);
      queue_entry(12'hAAA, '0, 1'b1);
      // saturate high, then pull back down; flag must stay set
      for (k = 0; k < 3; k++)
         queue_entry(STORE_DEPTH - 1, Q_MIN, 1'b0);
      queue_entry(0, Q_MIN, 1'b1);
      // saturate low
      for (k = 0; k < 4; k++)
         queue_entry(0, Q_MIN, k == 3);
      // element read straight after its own load
      queue_load(3, 32'h0003_0000, 1'b0);
      queue_entry(3, 32'h0002_0000, 1'b1);
      queue_load(3, 32'hFFFD_0000, 1'b0);
      queue_entry(3, Q_MAX, 1'b1);
      queue_entry(12'h555, Q_MIN, 1'b1);

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // random stretches, every third without request gaps
      for (seg = 0; seg < RANDOM_SEGS; seg++) begin
         while (request_backlog.size() != 0)
            @(posedge clock);
         req_idle_pct = (seg % 3 == 0) ? 0 : $urandom_range(5, 40);
         rsp_idle_pct = (seg % 3 == 2) ? 0 : $urandom_range(5, 40);
         goal = requests_total + SEG_REQUESTS;
         while (requests_total < goal) begin
            if ($urandom_range(0, 99) < 15) begin
               // a burst of loads, row_end noise included
               len = $urandom_range(1, 6);
               for (k = 0; k < len; k++)
                  queue_load($urandom_range(0, STORE_DEPTH - 1), pick_value(),
                             1'($urandom_range(0, 1)));
            end else begin
               heavy    = ($urandom_range(0, 9) == 0);
               heavy_up = 1'($urandom_range(0, 1));
               if (heavy)
                  len = $urandom_range(6, 16);
               else if ($urandom_range(0, 9) == 0)
                  len = $urandom_range(9, 24);
               else
                  len = $urandom_range(1, 6);
               for (k = 0; k < len; k++) begin
                  if (!heavy && $urandom_range(0, 9) == 0)
                     queue_load($urandom_range(0, STORE_DEPTH - 1), pick_value(), 1'b0);
                  col = pick_column();
                  // heavy rows push every product the same way to reach saturation
                  if (heavy)
                     coef = (loaded_val[col][VAL_W-1] ^ heavy_up) ? Q_MAX : Q_MIN;
                  else
                     coef = pick_value();
                  queue_entry(col, coef, k == len - 1);
               end
            end
         end
      end

      // last part: no idling, single-entry rows back to back
      while (request_backlog.size() != 0)
         @(posedge clock);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      goal = rows_issued + TAIL_ROWS;
      while (rows_issued < goal)
         queue_entry(pick_column(), pick_value(), 1'b1);

      while (requests_taken != requests_total || rows_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (rows_due.size() != 0)
         mismatches += rows_due.size();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
